@@ design/rsr_pkg.sv @@
// ----------------------------------------------------------------------------
// rsr_pkg: shared types and codes for the replacement selection run generator
// Holds the key type, the cell entry and command structs, the request and
// result codes and the configuration register layout.
// ----------------------------------------------------------------------------
`default_nettype none

package rsr_pkg;

    localparam int KEY_W = 32;
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef logic signed [KEY_W-1:0] key_t;

    // Request codes on the input channel.
    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_END    = 1'b1;

    // Result codes on the output channel.
    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_MARK = 1'b1;

    // One slot of the sorted chain.
    typedef struct packed {
        logic valid;
        logic frozen;
        key_t key;
    } entry_t;

    // Operation broadcast to every cell in a cycle.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_REPLACE,
        OP_POP,
        OP_THAW
    } op_t;

    typedef struct packed {
        op_t    op;
        entry_t x;
    } cmd_t;

endpackage

`default_nettype wire

@@ design/rsr_if.sv @@
// ----------------------------------------------------------------------------
// rsr_if: request and result channels
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsr_req_if;
    import rsr_pkg::*;

    logic valid;
    logic ready;
    logic req_type;
    key_t key;

    modport source (output valid, output req_type, output key, input ready);
    modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface rsr_res_if;
    import rsr_pkg::*;

    logic valid;
    logic ready;
    logic kind;
    key_t key_res;
    logic last;

    modport source (output valid, output kind, output key_res, output last, input ready);
    modport sink   (input valid, input kind, input key_res, input last, output ready);
endinterface

`default_nettype wire

@@ design/rsr_cell.sv @@
// ----------------------------------------------------------------------------
// rsr_cell: one slot of the sorted selection chain
// Holds one entry and, from the broadcast command and its two neighbours,
// works out its next entry so that the chain stays ordered with the smallest
// unfrozen key at the head, frozen keys after it and empty slots last.
// ----------------------------------------------------------------------------
`default_nettype none

module rsr_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  rsr_pkg::cmd_t        cmd,
    input  wire logic            first,
    input  rsr_pkg::entry_t      left_ent,
    input  wire logic            prev_ahead,
    input  rsr_pkg::entry_t      right_ent,
    input  wire logic            next_ahead,
    output rsr_pkg::entry_t      ent,
    output logic                 ahead
);
    import rsr_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;
    logic   key_le;

    // An entry sits ahead of the new key when it is live and either unfrozen
    // against a frozen newcomer, or of the same class with a key no larger.
    assign key_le = !($signed(cmd.x.key) < $signed(ent_reg.key));
    assign ahead  = ent_reg.valid
                    && ((!ent_reg.frozen && cmd.x.frozen)
                        || ((ent_reg.frozen == cmd.x.frozen) && key_le));

    always_comb
    begin
        ent_next = ent_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                if (ahead)
                begin
                    ent_next = ent_reg;
                end
                else if (prev_ahead)
                begin
                    ent_next = cmd.x;
                end
                else
                begin
                    ent_next = left_ent;
                end
            end
            OP_REPLACE:
            begin
                // The head leaves; entries ahead of the new key move up one.
                if (next_ahead)
                begin
                    ent_next = right_ent;
                end
                else if (first || ahead)
                begin
                    ent_next = cmd.x;
                end
                else
                begin
                    ent_next = ent_reg;
                end
            end
            OP_POP:
            begin
                ent_next = right_ent;
            end
            OP_THAW:
            begin
                ent_next.frozen = 1'b0;
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= '0;
        end
        else
        begin
            ent_reg <= ent_next;
        end
    end

    assign ent = ent_reg;

endmodule

`default_nettype wire

@@ design/rsr_chain.sv @@
// ----------------------------------------------------------------------------
// rsr_chain: row of selection cells
// Links the cells to their neighbours and presents the head entry.
// ----------------------------------------------------------------------------
`default_nettype none

module rsr_chain #(
    parameter int DEPTH = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  rsr_pkg::cmd_t        cmd,
    output rsr_pkg::entry_t      head
);
    import rsr_pkg::*;

    entry_t ents   [DEPTH];
    logic   aheads [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            entry_t left_ent;
            entry_t right_ent;
            logic   prev_ahead;
            logic   next_ahead;

            if (i == 0)
            begin : g_first
                assign left_ent   = '0;
                assign prev_ahead = 1'b1;
            end
            else
            begin : g_mid_l
                assign left_ent   = ents[i-1];
                assign prev_ahead = aheads[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_ent  = '0;
                assign next_ahead = 1'b0;
            end
            else
            begin : g_mid_r
                assign right_ent  = ents[i+1];
                assign next_ahead = aheads[i+1];
            end

            rsr_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .first      ((i == 0) ? 1'b1 : 1'b0),
                .left_ent   (left_ent),
                .prev_ahead (prev_ahead),
                .right_ent  (right_ent),
                .next_ahead (next_ahead),
                .ent        (ents[i]),
                .ahead      (aheads[i])
            );
        end
    endgenerate

    assign head = ents[0];

endmodule

`default_nettype wire

@@ design/replacement_selection_runs_top.sv @@
// ----------------------------------------------------------------------------
// replacement_selection_runs_top: run generator for an external sort
// Replacement selection over a sorted chain of cells, one cell per slot.
// ----------------------------------------------------------------------------
// Usage:
//   req carries record keys (req_type 0) and the end-of-input word
//   (req_type 1); res carries emitted keys and end-of-run markers, with last
//   set on the final result word caused by a request word.
//   cfg_we/cfg_wdata write entries_in_use; write it only while idle.
//   The first entries_in_use keys are stored as they are accepted, no result.
//   After that a key is accepted, then the smallest unfrozen key is emitted
//   into the output register and the new key takes its place in the chain;
//   an end-of-run marker is emitted before it when one must come first.
//   End of input drains the store at one result word per cycle while the
//   receiver is ready, up to MAX_ENTRIES + 2 words; the chain shifts one
//   place per emitted key.  An empty store gives no result on end of input.
//   req.ready is high only in the idle state.  A stalled receiver holds the
//   output register and the sequencer waits with it; nothing is lost.
//   Reset empties the store, clears the fill count and sets entries_in_use
//   to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module replacement_selection_runs_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    rsr_req_if.sink                      req,
    rsr_res_if.source                    res,
    input  wire logic                    cfg_we,
    input  wire logic [rsr_pkg::CFG_W-1:0] cfg_wdata
);
    import rsr_pkg::*;

    localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REPL,
        ST_DRAIN
    } state_t;

    state_t            state_reg;
    logic [FILL_W-1:0] fill_reg;
    key_t              x_key_reg;
    logic [CFG_W-1:0]  cfg_reg;
    logic              res_valid_reg;
    logic              res_kind_reg;
    key_t              res_key_reg;
    logic              res_last_reg;

    entry_t            head;
    cmd_t              cmd;
    logic              emit_ok;
    logic              emit;
    logic              fill_ok;
    logic [CMP_W-1:0]  cfg_ext;
    logic [CMP_W-1:0]  max_ext;
    logic [CMP_W-1:0]  fill_ext;
    logic [CMP_W-1:0]  active_ext;

    rsr_chain #(
        .DEPTH (MAX_ENTRIES)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .head  (head)
    );

    // Register values of zero act as one, values above the depth as the depth.
    assign cfg_ext    = CMP_W'(cfg_reg);
    assign max_ext    = CMP_W'(MAX_ENTRIES);
    assign fill_ext   = CMP_W'(fill_reg);
    assign active_ext = (cfg_ext == '0) ? CMP_W'(1)
                      : (cfg_ext > max_ext) ? max_ext : cfg_ext;
    assign fill_ok    = (fill_ext < active_ext) && (fill_ext < max_ext);

    assign emit_ok   = !res_valid_reg || res.ready;
    assign emit      = emit_ok && ((state_reg == ST_REPL) || (state_reg == ST_DRAIN));
    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd.op       = OP_NONE;
        cmd.x.valid  = 1'b1;
        cmd.x.frozen = 1'b0;
        cmd.x.key    = req.key;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && (req.req_type == REQ_RECORD) && fill_ok)
                begin
                    cmd.op = OP_INSERT;
                end
            end
            ST_REPL:
            begin
                cmd.x.key    = x_key_reg;
                cmd.x.frozen = $signed(x_key_reg) < $signed(head.key);
                if (emit_ok)
                begin
                    cmd.op = head.frozen ? OP_THAW : OP_REPLACE;
                end
            end
            ST_DRAIN:
            begin
                if (emit_ok && head.valid)
                begin
                    cmd.op = head.frozen ? OP_THAW : OP_POP;
                end
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            x_key_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_kind_reg  <= KIND_KEY;
            res_key_reg   <= '0;
            res_last_reg  <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        if (req.req_type == REQ_END)
                        begin
                            if (head.valid)
                            begin
                                state_reg <= ST_DRAIN;
                            end
                            else
                            begin
                                fill_reg <= '0;
                            end
                        end
                        else if (fill_ok)
                        begin
                            fill_reg <= fill_reg + FILL_W'(1);
                        end
                        else
                        begin
                            x_key_reg <= req.key;
                            state_reg <= ST_REPL;
                        end
                    end
                end
                ST_REPL:
                begin
                    if (emit_ok)
                    begin
                        if (head.frozen)
                        begin
                            // Every live key is frozen: close the run first.
                            res_kind_reg <= KIND_MARK;
                            res_key_reg  <= '0;
                            res_last_reg <= 1'b0;
                        end
                        else
                        begin
                            res_kind_reg <= KIND_KEY;
                            res_key_reg  <= head.key;
                            res_last_reg <= 1'b1;
                            state_reg    <= ST_IDLE;
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (emit_ok)
                    begin
                        if (head.valid && !head.frozen)
                        begin
                            res_kind_reg <= KIND_KEY;
                            res_key_reg  <= head.key;
                            res_last_reg <= 1'b0;
                        end
                        else
                        begin
                            // End of a run; frozen keys left over form the next one.
                            res_kind_reg <= KIND_MARK;
                            res_key_reg  <= '0;
                            res_last_reg <= !head.valid;
                            if (!head.valid)
                            begin
                                fill_reg  <= '0;
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res.valid   = res_valid_reg;
    assign res.kind    = res_kind_reg;
    assign res.key_res = res_key_reg;
    assign res.last    = res_last_reg;

endmodule

`default_nettype wire
